// ===== hw/rtl/stt_pkg.sv =====
// Package for the script token scanner: result type, token kinds, character codes,
// character classes and the keyword table.
// No dependencies.
`timescale 1ns / 1ps
package stt_pkg;

    localparam int RES_MAX = 3;

    typedef logic [2:0] t_kind;

    localparam t_kind K_STRING  = 3'd0;
    localparam t_kind K_NUMBER  = 3'd1;
    localparam t_kind K_IDENT   = 3'd2;
    localparam t_kind K_KEYWORD = 3'd3;
    localparam t_kind K_OP      = 3'd4;
    localparam t_kind K_EOF     = 3'd5;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  keyword_id;
        logic [7:0]  op_first;
        logic [7:0]  op_second;
        logic [15:0] first_line;
        logic [15:0] first_col;
        logic [31:0] start_offset;
        logic [15:0] length;
        logic        unterminated;
        logic        last;
    } t_result;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int KW_COUNT = 18;

    // keywords right-aligned, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h6C6574, 64'h666E, 64'h656E64, 64'h6966, 64'h656C6966, 64'h656C7365,
        64'h7768696C65, 64'h666F72, 64'h696E, 64'h72657475726E, 64'h616E64,
        64'h6F72, 64'h6E6F74, 64'h74727565, 64'h66616C7365, 64'h6E696C,
        64'h627265616B, 64'h636F6E74696E7565
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6, 4'd3,
        4'd2, 4'd3, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8
    };

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c == CH_UNDER) || is_alpha(c) || is_dec_digit(c);
    endfunction

    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        return ((a == CH_DOT) && (b == CH_DOT)) || ((a == CH_EQ) && (b == CH_EQ)) ||
               ((a == CH_BANG) && (b == CH_EQ)) || ((a == CH_LT) && (b == CH_EQ)) ||
               ((a == CH_GT) && (b == CH_EQ)) || ((a == CH_EQ) && (b == CH_GT));
    endfunction

    function automatic logic is_pair_start(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    endfunction

    // {hit, index}
    function automatic logic [5:0] kw_lookup(input logic [63:0] text, input logic [3:0] len);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if ((KW_LEN[i] == len) && (KW_TEXT[i] == text)) begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/stt_if.sv =====
// Channel interfaces of the script token scanner: source bytes in, token descriptors out.
// Depends on nothing.
`timescale 1ns / 1ps
interface stt_src_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] ch;

    modport source (output valid, func, ch, input ready);
    modport sink (input valid, func, ch, output ready);
endinterface

interface stt_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  keyword_id;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic [15:0] first_line;
    logic [15:0] first_col;
    logic [31:0] start_offset;
    logic [15:0] length;
    logic        unterminated;
    logic        last;

    modport source (output valid, kind, keyword_id, op_first, op_second, first_line,
                    first_col, start_offset, length, unterminated, last, input ready);
    modport sink (input valid, kind, keyword_id, op_first, op_second, first_line,
                  first_col, start_offset, length, unterminated, last, output ready);
endinterface

// ===== hw/rtl/stt_core.sv =====
// Scanner state machine: position counters, token start and one-byte lookahead.
// Builds the up to three descriptors an item causes. Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_core #(
    parameter int POS_BITS    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic              i_func,
    input  logic [7:0]        i_ch,
    output stt_pkg::t_result  o_res [stt_pkg::RES_MAX],
    output logic [1:0]        o_cnt
);
    import stt_pkg::*;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_MINUS   = 4'd2;
    localparam logic [3:0] M_OPPEND  = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_ESC     = 4'd5;
    localparam logic [3:0] M_ZERO    = 4'd6;
    localparam logic [3:0] M_INT     = 4'd7;
    localparam logic [3:0] M_HEX     = 4'd8;
    localparam logic [3:0] M_DOT     = 4'd9;
    localparam logic [3:0] M_FRAC    = 4'd10;
    localparam logic [3:0] M_EXP0    = 4'd11;
    localparam logic [3:0] M_EXPD    = 4'd12;
    localparam logic [3:0] M_IDENT   = 4'd13;

    localparam logic [POS_BITS-1:0] P_ONE = POS_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] O_ONE = OFFSET_BITS'(1);

    logic [3:0]             r_mode, n_mode;
    logic [POS_BITS-1:0]    r_line, n_line, r_col, n_col;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [POS_BITS-1:0]    r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0] r_tok_off, n_tok_off;
    logic [POS_BITS-1:0]    r_tok_len, n_tok_len;
    logic [63:0]            r_ident, n_ident;
    logic [7:0]             r_pend, n_pend;
    logic                   r_quote, n_quote;

    t_result    res [RES_MAX];
    logic [1:0] k;
    logic       go_idle, do_pend;
    logic [5:0] kw;
    logic       kw_hit;
    t_kind      word_kind;
    logic [4:0] word_id;

    function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                    input logic [POS_BITS-1:0] b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
    endfunction

    function automatic t_result mk_res(input t_kind kind, input logic [4:0] id,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input logic [POS_BITS-1:0] ln,
                                       input logic [POS_BITS-1:0] cl,
                                       input logic [OFFSET_BITS-1:0] off,
                                       input logic [POS_BITS-1:0] len, input logic ut);
        t_result r;
        logic [POS_BITS+15:0]    lx, cx, nx;
        logic [OFFSET_BITS+31:0] ox;
        lx = {16'b0, ln};
        cx = {16'b0, cl};
        nx = {16'b0, len};
        ox = {32'b0, off};
        r.kind         = kind;
        r.keyword_id   = id;
        r.op_first     = a;
        r.op_second    = b;
        r.first_line   = lx[15:0];
        r.first_col    = cx[15:0];
        r.start_offset = ox[31:0];
        r.length       = nx[15:0];
        r.unterminated = ut;
        r.last         = 1'b0;
        return r;
    endfunction

    // keyword match works on the held characters of the current identifier
    always_comb begin
        kw        = kw_lookup(r_ident, r_tok_len[3:0]);
        kw_hit    = kw[5] && (r_tok_len <= POS_BITS'(8));
        word_kind = kw_hit ? K_KEYWORD : K_IDENT;
        word_id   = kw_hit ? kw[4:0] : 5'd0;
    end

    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_col      = r_col;
        n_off      = r_off;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_off  = r_tok_off;
        n_tok_len  = r_tok_len;
        n_ident    = r_ident;
        n_pend     = r_pend;
        n_quote    = r_quote;
        res        = '{default: '0};
        k          = 2'd0;
        go_idle    = 1'b0;
        do_pend    = 1'b0;
        if (i_func) begin
            unique case (r_mode)
                M_MINUS, M_OPPEND: begin
                    res[k] = mk_res(K_OP, 5'd0, r_pend, 8'd0, r_tok_line, r_tok_col,
                                    r_tok_off, r_tok_len, 1'b0);
                    k = k + 2'd1;
                end
                M_STRING, M_ESC: begin
                    res[k] = mk_res(K_STRING, 5'd0, 8'd0, 8'd0, r_tok_line, r_tok_col,
                                    r_tok_off, r_tok_len, 1'b1);
                    k = k + 2'd1;
                end
                M_ZERO, M_INT, M_HEX, M_FRAC, M_EXP0, M_EXPD: begin
                    res[k] = mk_res(K_NUMBER, 5'd0, 8'd0, 8'd0, r_tok_line, r_tok_col,
                                    r_tok_off, r_tok_len, 1'b0);
                    k = k + 2'd1;
                end
                M_DOT: begin
                    res[k] = mk_res(K_NUMBER, 5'd0, 8'd0, 8'd0, r_tok_line, r_tok_col,
                                    r_tok_off, r_tok_len, 1'b0);
                    k = k + 2'd1;
                    res[k] = mk_res(K_OP, 5'd0, CH_DOT, 8'd0, r_tok_line,
                                    sat_add(r_tok_col, r_tok_len), r_off - O_ONE, P_ONE, 1'b0);
                    k = k + 2'd1;
                end
                M_IDENT: begin
                    res[k] = mk_res(word_kind, word_id, 8'd0, 8'd0, r_tok_line, r_tok_col,
                                    r_tok_off, r_tok_len, 1'b0);
                    k = k + 2'd1;
                end
                default: begin
                end
            endcase
            res[k] = mk_res(K_EOF, 5'd0, 8'd0, 8'd0, r_line, r_col, r_off, '0, 1'b0);
            k = k + 2'd1;
            // back to the reset state for the next source
            n_mode     = M_IDLE;
            n_line     = P_ONE;
            n_col      = P_ONE;
            n_off      = '0;
            n_tok_line = P_ONE;
            n_tok_col  = P_ONE;
            n_tok_off  = '0;
            n_tok_len  = '0;
            n_ident    = '0;
            n_pend     = '0;
            n_quote    = 1'b0;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (i_ch == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                end
                M_MINUS: begin
                    if (i_ch == CH_MINUS) begin
                        n_mode = M_COMMENT;
                    end else begin
                        res[k] = mk_res(K_OP, 5'd0, CH_MINUS, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_OPPEND: do_pend = 1'b1;
                M_STRING: begin
                    n_tok_len = sat_add(r_tok_len, P_ONE);
                    if (i_ch == CH_BSL) begin
                        n_mode = M_ESC;
                    end else if (i_ch == (r_quote ? CH_SQ : CH_DQ)) begin
                        res[k] = mk_res(K_STRING, 5'd0, 8'd0, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_ESC: begin
                    n_tok_len = sat_add(r_tok_len, P_ONE);
                    n_mode    = M_STRING;
                end
                M_ZERO, M_INT, M_FRAC: begin
                    if ((r_mode == M_ZERO) && ((i_ch == CH_LO_X) || (i_ch == CH_UP_X))) begin
                        n_tok_len = sat_add(r_tok_len, P_ONE);
                        n_mode    = M_HEX;
                    end else if (is_dec_digit(i_ch)) begin
                        n_tok_len = sat_add(r_tok_len, P_ONE);
                        n_mode    = (r_mode == M_FRAC) ? M_FRAC : M_INT;
                    end else if ((i_ch == CH_DOT) && (r_mode != M_FRAC)) begin
                        n_mode = M_DOT;
                    end else if ((i_ch == CH_LO_E) || (i_ch == CH_UP_E)) begin
                        n_tok_len = sat_add(r_tok_len, P_ONE);
                        n_mode    = M_EXP0;
                    end else begin
                        res[k] = mk_res(K_NUMBER, 5'd0, 8'd0, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_HEX, M_EXP0, M_EXPD: begin
                    if (((r_mode == M_HEX) && is_hex(i_ch)) ||
                        ((r_mode != M_HEX) && is_dec_digit(i_ch)) ||
                        ((r_mode == M_EXP0) && ((i_ch == CH_PLUS) || (i_ch == CH_MINUS)))) begin
                        n_tok_len = sat_add(r_tok_len, P_ONE);
                        n_mode    = (r_mode == M_HEX) ? M_HEX : M_EXPD;
                    end else begin
                        res[k] = mk_res(K_NUMBER, 5'd0, 8'd0, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_dec_digit(i_ch)) begin
                        n_tok_len = sat_add(r_tok_len, POS_BITS'(2));
                        n_mode    = M_FRAC;
                    end else begin
                        res[k] = mk_res(K_NUMBER, 5'd0, 8'd0, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        // the held dot becomes a lookahead operator at its own place
                        n_tok_col = sat_add(r_tok_col, r_tok_len);
                        n_tok_off = r_off - O_ONE;
                        n_tok_len = P_ONE;
                        n_pend    = CH_DOT;
                        do_pend   = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(i_ch)) begin
                        if (r_tok_len < POS_BITS'(8)) begin
                            n_ident = {r_ident[55:0], i_ch};
                        end
                        n_tok_len = sat_add(r_tok_len, P_ONE);
                    end else begin
                        res[k] = mk_res(word_kind, word_id, 8'd0, 8'd0, n_tok_line,
                                        n_tok_col, n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                default: go_idle = 1'b1;
            endcase

            if (do_pend) begin
                if (is_pair(n_pend, i_ch)) begin
                    n_tok_len = POS_BITS'(2);
                    res[k] = mk_res(K_OP, 5'd0, n_pend, i_ch, n_tok_line, n_tok_col,
                                    n_tok_off, n_tok_len, 1'b0);
                    k = k + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    res[k] = mk_res(K_OP, 5'd0, n_pend, 8'd0, n_tok_line, n_tok_col,
                                    n_tok_off, n_tok_len, 1'b0);
                    k = k + 2'd1;
                    go_idle = 1'b1;
                end
            end

            if (go_idle) begin
                n_mode = M_IDLE;
                if ((i_ch == CH_SP) || (i_ch == CH_TAB) || (i_ch == CH_CR) || (i_ch == CH_NL)) begin
                    n_mode = M_IDLE;
                end else if (i_ch == CH_HASH) begin
                    n_mode = M_COMMENT;
                end else begin
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    n_tok_off  = r_off;
                    n_tok_len  = P_ONE;
                    if (i_ch == CH_MINUS) begin
                        n_pend = i_ch;
                        n_mode = M_MINUS;
                    end else if ((i_ch == CH_DQ) || (i_ch == CH_SQ)) begin
                        n_quote = (i_ch == CH_SQ);
                        n_mode  = M_STRING;
                    end else if (is_dec_digit(i_ch)) begin
                        n_mode = (i_ch == CH_ZERO) ? M_ZERO : M_INT;
                    end else if ((i_ch == CH_UNDER) || is_alpha(i_ch)) begin
                        n_ident = {56'b0, i_ch};
                        n_mode  = M_IDENT;
                    end else if (is_pair_start(i_ch)) begin
                        n_pend = i_ch;
                        n_mode = M_OPPEND;
                    end else begin
                        res[k] = mk_res(K_OP, 5'd0, i_ch, 8'd0, n_tok_line, n_tok_col,
                                        n_tok_off, n_tok_len, 1'b0);
                        k = k + 2'd1;
                    end
                end
            end

            if (i_ch == CH_NL) begin
                n_line = sat_add(r_line, P_ONE);
                n_col  = P_ONE;
            end else begin
                n_col = sat_add(r_col, P_ONE);
            end
            n_off = r_off + O_ONE;
        end
        if (k != 2'd0) begin
            res[k - 2'd1].last = 1'b1;
        end
    end

    assign o_res = res;
    assign o_cnt = k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_line     <= P_ONE;
            r_col      <= P_ONE;
            r_off      <= '0;
            r_tok_line <= P_ONE;
            r_tok_col  <= P_ONE;
            r_tok_off  <= '0;
            r_tok_len  <= '0;
            r_ident    <= '0;
            r_pend     <= '0;
            r_quote    <= 1'b0;
        end else if (i_acc) begin
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_col      <= n_col;
            r_off      <= n_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_off  <= n_tok_off;
            r_tok_len  <= n_tok_len;
            r_ident    <= n_ident;
            r_pend     <= n_pend;
            r_quote    <= n_quote;
        end
    end

endmodule

// ===== hw/rtl/stt_outq.sv =====
// Result buffer: holds one item's descriptors, handed out one per cycle while i_ready is high.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [1:0]        i_cnt,
    input  stt_pkg::t_result  i_res [stt_pkg::RES_MAX],
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output stt_pkg::t_result  o_data
);
    import stt_pkg::*;

    t_result    r_q [RES_MAX];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_data     = r_q[0];
    assign pop        = o_valid && i_ready;
    // a new item is taken once the buffer holds at most the result leaving now
    assign o_can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q <= i_res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

endmodule

// ===== hw/rtl/script_token_scanner_top.sv =====
// Script token scanner top level: byte channel in, token descriptor channel out.
// Latency: the first descriptor of an item is offered the cycle after the item is taken.
// Throughput: one item per cycle while each item gives at most one descriptor and the output is
// ready; an item giving two or three holds input ready low until the last of them is leaving.
// Reset: synchronous, active low; position 1:1, offset 0, scanner idle, buffer empty.
`timescale 1ns / 1ps
module script_token_scanner_top #(
    parameter int POS_BITS    = 16,
    parameter int OFFSET_BITS = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    stt_src_if.sink   i_src,
    stt_tok_if.source o_tok
);
    import stt_pkg::*;

    t_result    res [RES_MAX];
    logic [1:0] cnt;
    logic       can_push;
    logic       acc;
    t_result    head;

    assign i_src.ready = can_push;
    assign acc         = i_src.valid && can_push;

    stt_core #(
        .POS_BITS    (POS_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_func  (i_src.func),
        .i_ch    (i_src.ch),
        .o_res   (res),
        .o_cnt   (cnt)
    );

    stt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (acc),
        .i_cnt      (cnt),
        .i_res      (res),
        .o_can_push (can_push),
        .o_valid    (o_tok.valid),
        .i_ready    (o_tok.ready),
        .o_data     (head)
    );

    assign o_tok.kind         = head.kind;
    assign o_tok.keyword_id   = head.keyword_id;
    assign o_tok.op_first     = head.op_first;
    assign o_tok.op_second    = head.op_second;
    assign o_tok.first_line   = head.first_line;
    assign o_tok.first_col    = head.first_col;
    assign o_tok.start_offset = head.start_offset;
    assign o_tok.length       = head.length;
    assign o_tok.unterminated = head.unterminated;
    assign o_tok.last         = head.last;

    // an end item always yields at least the end-of-file descriptor
    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_src.func) |-> (cnt != 2'd0))
        else $error("end item produced no descriptor");

    a_end_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_src.func) |=> o_tok.valid)
        else $error("descriptor of end item not offered");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !can_push |-> o_tok.valid)
        else $error("input stalled with empty result buffer");

endmodule
